// File: rtl/core/zsaq_pkg.sv
// zsaq_pkg: shared widths, types and constants for the z-score anomaly qualifier.
// No dependencies; used by every module of the block.
`default_nettype none

package zsaq_pkg;

    localparam int NUM_METRICS = 4;
    localparam int FRAC_BITS   = 8;

    localparam int IDX_W    = 2;
    localparam int VALUE_W  = 32;
    localparam int STDDEV_W = 31;
    localparam int ZSCORE_W = 16;
    localparam int HIT_W    = 8;
    localparam int COUNT_W  = 16;
    localparam int RUN_W    = 8;

    localparam int DIFF_W = VALUE_W + 1;
    localparam int LHS_W  = DIFF_W + FRAC_BITS;
    localparam int PROD_W = ZSCORE_W + STDDEV_W;
    localparam int CMP_W  = (LHS_W > PROD_W) ? LHS_W : PROD_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = STDDEV_W;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [DIFF_W-1:0]  t_diff;
    typedef logic [PROD_W-1:0]  t_prod;
    typedef logic [CMP_W-1:0]   t_cmp;
    typedef logic [RUN_W-1:0]   t_run;
    typedef logic [HIT_W-1:0]   t_hit;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_idx   HEARTBEAT_METRIC    = t_idx'(1);
    localparam t_count HEARTBEAT_MIN_COUNT = t_count'(2);
    localparam t_run   RUN_MAX             = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZSCORE_THRESHOLD = 2'd0,
        CFG_MIN_STDDEV       = 2'd1,
        CFG_HIT_THRESHOLD    = 2'd2
    } t_cfg_reg;

    // request from the pipeline's last stage to the per-metric state
    typedef struct packed {
        logic commit;    // item leaves the last stage this cycle
        logic in_range;
        logic eval;
        logic anom;
        t_idx idx;
    } t_upd;

    // outcome of that request, before the state register update
    typedef struct packed {
        logic raised;
        logic cleared;
        logic active;
    } t_res;

endpackage

`default_nettype wire

// File: rtl/core/zsaq_state.sv
// zsaq_state: per-metric run counters and alert flags with saturating update.
// Depends on zsaq_pkg.
`default_nettype none

module zsaq_state (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire zsaq_pkg::t_hit  i_hit_thr,
    input  wire zsaq_pkg::t_upd  i_upd,
    output zsaq_pkg::t_res       o_res
);

    zsaq_pkg::t_run r_anom_run [zsaq_pkg::NUM_METRICS];
    zsaq_pkg::t_run r_norm_run [zsaq_pkg::NUM_METRICS];
    logic           r_flag     [zsaq_pkg::NUM_METRICS];

    zsaq_pkg::t_run n_anom_run;
    zsaq_pkg::t_run n_norm_run;
    logic           n_flag;
    logic           cur_flag;
    logic           do_write;

    always_comb begin
        zsaq_pkg::t_run a_cur;
        zsaq_pkg::t_run n_cur;
        a_cur    = '0;
        n_cur    = '0;
        cur_flag = 1'b0;
        if (i_upd.in_range) begin
            a_cur    = r_anom_run[i_upd.idx];
            n_cur    = r_norm_run[i_upd.idx];
            cur_flag = r_flag[i_upd.idx];
        end

        n_anom_run = a_cur;
        n_norm_run = n_cur;
        n_flag     = cur_flag;
        o_res      = '0;

        if (i_upd.eval) begin
            if (i_upd.anom) begin
                n_anom_run = (a_cur < zsaq_pkg::RUN_MAX) ? a_cur + 1'b1 : a_cur;
                n_norm_run = '0;
                if (!cur_flag && (n_anom_run >= i_hit_thr)) begin
                    n_flag       = 1'b1;
                    o_res.raised = 1'b1;
                end
            end else begin
                n_norm_run = (n_cur < zsaq_pkg::RUN_MAX) ? n_cur + 1'b1 : n_cur;
                n_anom_run = '0;
                if (cur_flag && (n_norm_run >= i_hit_thr)) begin
                    n_flag        = 1'b0;
                    o_res.cleared = 1'b1;
                end
            end
        end
        o_res.active = n_flag;
    end

    assign do_write = i_upd.commit && i_upd.eval && i_upd.in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < zsaq_pkg::NUM_METRICS; m++) begin
                r_anom_run[m] <= '0;
                r_norm_run[m] <= '0;
                r_flag[m]     <= 1'b0;
            end
        end else if (do_write) begin
            r_anom_run[i_upd.idx] <= n_anom_run;
            r_norm_run[i_upd.idx] <= n_norm_run;
            r_flag[i_upd.idx]     <= n_flag;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/zscore_anomaly_qualifier_top.sv
// zscore_anomaly_qualifier_top: registered single-pass z-score anomaly qualifier with alert tracking.
// Depends on zsaq_pkg and zsaq_state.
`default_nettype none

// Usage
//   Input channel (i_in_valid / o_in_stall): one metric sample per item with
//   its baseline mean, deviation and gating counts; taken at a rising edge
//   where i_in_valid is high and o_in_stall is low.
//   Output channel (o_out_valid / i_out_stall): exactly one result item per
//   input item, in order: metric id, gating outcome, anomaly bit and the
//   alert raise / clear / state flags of that metric.
//   Configuration: write port (i_cfg_wr_en, i_cfg_index, i_cfg_wdata) for the
//   z-score limit, minimum deviation and hit threshold; write only while idle.
// Timing
//   Input register, then one combinational pass (|obs - mean|, the 16x31
//   product, compare and per-metric counter update) into the result register.
//   Throughput is one item per cycle while i_out_stall is low; state is read and
//   written in the same pass, so back-to-back samples are exact.
// Reset: synchronous, active low; both registers emptied, run counters and
//   alert flags cleared, configuration back to 3.0 / 1.0 / 3.
// Backpressure: while i_out_stall holds the result the input register still
//   fills; o_in_stall rises only when both registers are full.

module zscore_anomaly_qualifier_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [zsaq_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [zsaq_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // input channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [zsaq_pkg::IDX_W-1:0]           i_metric_index,
    input  wire logic signed [zsaq_pkg::VALUE_W-1:0]  i_observed_value,
    input  wire logic signed [zsaq_pkg::VALUE_W-1:0]  i_baseline_mean,
    input  wire logic [zsaq_pkg::STDDEV_W-1:0]        i_baseline_stddev,
    input  wire logic                                 i_learning_phase,
    input  wire logic [zsaq_pkg::COUNT_W-1:0]         i_total_samples,
    input  wire logic [zsaq_pkg::COUNT_W-1:0]         i_metric_sample_count,
    // output channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic [zsaq_pkg::IDX_W-1:0]                o_metric_id,
    output logic                                      o_evaluated,
    output logic                                      o_anomalous,
    output logic                                      o_alert_raised,
    output logic                                      o_alert_cleared,
    output logic                                      o_alert_state
);

    // configuration registers
    logic [zsaq_pkg::ZSCORE_W-1:0] r_zscore_thr;
    logic [zsaq_pkg::STDDEV_W-1:0] r_min_stddev;
    zsaq_pkg::t_hit                r_hit_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zscore_thr <= zsaq_pkg::ZSCORE_W'(768);
            r_min_stddev <= zsaq_pkg::STDDEV_W'(256);
            r_hit_thr    <= zsaq_pkg::HIT_W'(3);
        end else if (i_cfg_wr_en) begin
            unique case (zsaq_pkg::t_cfg_reg'(i_cfg_index))
                zsaq_pkg::CFG_ZSCORE_THRESHOLD: r_zscore_thr <= i_cfg_wdata[zsaq_pkg::ZSCORE_W-1:0];
                zsaq_pkg::CFG_MIN_STDDEV:       r_min_stddev <= i_cfg_wdata[zsaq_pkg::STDDEV_W-1:0];
                zsaq_pkg::CFG_HIT_THRESHOLD:    r_hit_thr    <= i_cfg_wdata[zsaq_pkg::HIT_W-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // handshake: each register loads when it is empty or its content moves on
    logic r_s1_valid, r_out_valid;
    logic out_ready, s1_ready;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign s1_ready   = !r_s1_valid || out_ready;
    assign o_in_stall = !s1_ready;

    // input register: capture the item
    zsaq_pkg::t_idx                   r1_idx;
    logic signed [zsaq_pkg::VALUE_W-1:0] r1_obs, r1_mean;
    logic [zsaq_pkg::STDDEV_W-1:0]    r1_stddev;
    logic                             r1_learning;
    zsaq_pkg::t_count                 r1_total, r1_mcount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_in_valid) begin
            r1_idx      <= i_metric_index;
            r1_obs      <= i_observed_value;
            r1_mean     <= i_baseline_mean;
            r1_stddev   <= i_baseline_stddev;
            r1_learning <= i_learning_phase;
            r1_total    <= i_total_samples;
            r1_mcount   <= i_metric_sample_count;
        end
    end

    // gating, |obs - mean|, threshold * deviation
    logic signed [zsaq_pkg::DIFF_W-1:0] w_diff;
    zsaq_pkg::t_diff                    w_absdiff;
    zsaq_pkg::t_prod                    w_prod;
    logic                               w_in_range, w_eval, w_big;

    assign w_diff    = zsaq_pkg::DIFF_W'(r1_obs) - zsaq_pkg::DIFF_W'(r1_mean);
    assign w_absdiff = w_diff[zsaq_pkg::DIFF_W-1] ? zsaq_pkg::t_diff'(-w_diff)
                                                 : zsaq_pkg::t_diff'(w_diff);
    assign w_prod    = zsaq_pkg::t_prod'(r_zscore_thr) * zsaq_pkg::t_prod'(r1_stddev);
    assign w_big     = (r1_stddev >= r_min_stddev);

    assign w_in_range = (32'(r1_idx) < zsaq_pkg::NUM_METRICS);
    assign w_eval     = w_in_range && !r1_learning
                     && !(r1_total < zsaq_pkg::t_count'(r_hit_thr))
                     && !((r1_idx == zsaq_pkg::HEARTBEAT_METRIC)
                          && (r1_mcount < zsaq_pkg::HEARTBEAT_MIN_COUNT));

    // compare and per-metric state update
    zsaq_pkg::t_cmp w_lhs, w_rhs;
    logic           w_anom;
    zsaq_pkg::t_upd w_upd;
    zsaq_pkg::t_res w_res;

    assign w_lhs  = zsaq_pkg::t_cmp'(w_absdiff) << zsaq_pkg::FRAC_BITS;
    assign w_rhs  = zsaq_pkg::t_cmp'(w_prod);
    assign w_anom = w_eval && w_big && (w_lhs > w_rhs);

    always_comb begin
        w_upd.commit   = r_s1_valid && out_ready;
        w_upd.in_range = w_in_range;
        w_upd.eval     = w_eval;
        w_upd.anom     = w_anom;
        w_upd.idx      = r1_idx;
    end

    zsaq_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hit_thr (r_hit_thr),
        .i_upd     (w_upd),
        .o_res     (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_s1_valid) begin
            o_metric_id     <= r1_idx;
            o_evaluated     <= w_eval;
            o_anomalous     <= w_anom;
            o_alert_raised  <= w_res.raised;
            o_alert_cleared <= w_res.cleared;
            o_alert_state   <= w_res.active;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/core/zsaq_checker.sv
// zsaq_checker: port-level assertions for the anomaly qualifier, bound to the top level.
// Depends on zscore_anomaly_qualifier_top (bind target) and zsaq_pkg.
`default_nettype none

module zsaq_checker (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 o_out_valid,
    input wire logic                                 i_out_stall,
    input wire logic [zsaq_pkg::IDX_W-1:0]           o_metric_id,
    input wire logic                                 o_evaluated,
    input wire logic                                 o_anomalous,
    input wire logic                                 o_alert_raised,
    input wire logic                                 o_alert_cleared,
    input wire logic                                 o_alert_state
);

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_metric_id)
            && $stable(o_evaluated) && $stable(o_anomalous) && $stable(o_alert_raised)
            && $stable(o_alert_cleared) && $stable(o_alert_state))
        else $error("stalled result changed");

    // a raise comes only from an evaluated anomalous sample and leaves the alert on
    a_raise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_alert_raised |-> o_evaluated && o_anomalous && o_alert_state)
        else $error("inconsistent alert raise");

    // a clear comes only from an evaluated normal sample and leaves the alert off
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_alert_cleared |-> o_evaluated && !o_anomalous && !o_alert_state)
        else $error("inconsistent alert clear");

    // a skipped sample changes nothing
    a_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evaluated |-> !o_anomalous && !o_alert_raised && !o_alert_cleared)
        else $error("skipped sample reported activity");

endmodule

bind zscore_anomaly_qualifier_top zsaq_checker u_zsaq_checker (.*);

`default_nettype wire
